/* hdl/tfnt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfnt_pkg: shared constants and types for the touch finger note tracker
// Table sizes, screen geometry, field widths, status codes and config
// register indexes.
// ----------------------------------------------------------------------------
package tfnt_pkg;

    // Table and screen geometry
    localparam int MAX_TOUCHES = 16;
    localparam int SCREEN_W    = 1024;
    localparam int SCREEN_H    = 1024;
    localparam int BASE_PITCH  = 30;

    // Field widths
    localparam int POS_W   = 10;
    localparam int ID_W    = 16;
    localparam int CW_W    = 11;
    localparam int STEP_W  = 16;
    localparam int PITCH_W = 16;
    localparam int STAT_W  = 2;

    // Touch table
    localparam int IDX_W   = (MAX_TOUCHES > 1) ? $clog2(MAX_TOUCHES) : 1;
    localparam int CNT_W   = $clog2(MAX_TOUCHES + 1);
    localparam int ENTRY_W = 2 * POS_W + ID_W;

    // Arithmetic
    localparam int DYR_W  = $clog2(SCREEN_H + 1);
    localparam int DIVC_W = $clog2(POS_W + 1);
    localparam int MUL_W  = 16;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIST_W = 2 * POS_W + 1;
    localparam int ACC_W  = PROD_W + 1;

    // Stream and config port widths
    localparam int S_TDATA_W  = ((2 * POS_W + ID_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((PITCH_W + ID_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP     = 2'd2;

    // Config reset values
    localparam logic [CW_W-1:0]   RST_COLUMN_WIDTH = 11'd64;
    localparam logic [STEP_W-1:0] RST_COLUMN_STEP  = 16'd1280;
    localparam logic [STEP_W-1:0] RST_ROW_STEP     = 16'd2048;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_NOTE_ON  = 2'd0,
        ST_NOTE_OFF = 2'd1,
        ST_NO_TOUCH = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

endpackage

/* hdl/tfnt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfnt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tfnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/touch_finger_note_tracker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_finger_note_tracker_top: active touch table with pitch mapping
// Touch down: restoring divide for the column, then pitch from the shared
// multiplier, note on and append. Touch up: nearest-touch search with the
// shared multiplier, note off and in-order removal from the table RAM.
// ----------------------------------------------------------------------------
// Touch down: from input transfer to result, 10 divide steps, then
//   2 multiplier passes, finish and output load.
// Touch up: a search over the N stored touches on the shared multiplier,
//   then the N-1-k entries after the matched entry k shift down through the RAM port.
// Table full or empty table: straight to the output load. One item at a time.
// Reset (i_rst_n low, synchronous) empties the table, restores the config
//   registers and drops any pending result; no clearing pass.
module touch_finger_note_tracker_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: pos_x [9:0], pos_y [19:10], new_note_id [35:20], zero pad
    input  logic [tfnt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: mode [0]
    input  logic                              s_axis_tuser,
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: pitch [15:0], note_id [31:16]
    output logic [tfnt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // tuser: status [1:0]
    output logic [tfnt_pkg::STAT_W-1:0]       m_axis_tuser,
    // Config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tfnt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tfnt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import tfnt_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_DIV      = 14'b00000000000010,
        S_MUL_COL  = 14'b00000000000100,
        S_MUL_ROW  = 14'b00000000001000,
        S_DOWN_FIN = 14'b00000000010000,
        S_SRCH_RD  = 14'b00000000100000,
        S_SRCH_X   = 14'b00000001000000,
        S_SRCH_Y   = 14'b00000010000000,
        S_SRCH_CMP = 14'b00000100000000,
        S_NOTE_RD  = 14'b00001000000000,
        S_NOTE     = 14'b00010000000000,
        S_RM_RD    = 14'b00100000000000,
        S_RM_WR    = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } t_state;

    // Control registers
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_best, n_best;
    logic [DIVC_W-1:0]   r_div_cnt, n_div_cnt;
    logic                r_out_valid, n_out_valid;
    logic [CW_W-1:0]     r_col_width;
    logic [STEP_W-1:0]   r_col_step;
    logic [STEP_W-1:0]   r_row_step;

    // Payload registers
    logic [POS_W-1:0]    r_x, n_x;
    logic [POS_W-1:0]    r_y, n_y;
    logic [ID_W-1:0]     r_nid, n_nid;
    logic [DYR_W-1:0]    r_dyr, n_dyr;
    logic [POS_W-1:0]    r_quot, n_quot;
    logic [CW_W-1:0]     r_rem, n_rem;
    logic [PROD_W-1:0]   r_prod;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [POS_W-1:0]    r_dy, n_dy;
    logic [DIST_W-1:0]   r_sq, n_sq;
    logic [DIST_W-1:0]   r_best_d, n_best_d;
    t_status             r_res_status, n_res_status;
    logic [PITCH_W-1:0]  r_res_pitch, n_res_pitch;
    logic [ID_W-1:0]     r_res_id, n_res_id;
    t_status             r_out_status, n_out_status;
    logic [PITCH_W-1:0]  r_out_pitch, n_out_pitch;
    logic [ID_W-1:0]     r_out_id, n_out_id;

    // Table RAM ports
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    // Shared multiplier
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   mul_p;

    // Misc combinational
    logic                s_xfer;
    logic [POS_W-1:0]    in_x, in_y, x_c, y_c;
    logic [CW_W-1:0]     cw_eff;
    logic [CW_W:0]       div_trial;
    logic                div_ge;
    logic [POS_W-1:0]    ent_x, ent_y;
    logic [ID_W-1:0]     ent_id;
    logic [POS_W-1:0]    abs_dx, abs_dy;
    logic [DIST_W-1:0]   sum_sq;
    logic [ACC_W-1:0]    pitch_sum;
    logic [CNT_W-1:0]    idx_p1, idx_p2, best_p1;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Input unpack and clamp to the screen
    assign in_x = s_axis_tdata[POS_W-1:0];
    assign in_y = s_axis_tdata[2*POS_W-1:POS_W];
    assign x_c  = (32'(in_x) >= SCREEN_W) ? POS_W'(SCREEN_W - 1) : in_x;
    assign y_c  = (32'(in_y) >= SCREEN_H) ? POS_W'(SCREEN_H - 1) : in_y;

    // Divider step: zero width counts as one
    assign cw_eff    = (r_col_width == '0) ? CW_W'(1) : r_col_width;
    assign div_trial = {r_rem, r_quot[POS_W-1]};
    assign div_ge    = (div_trial >= {1'b0, cw_eff});

    // Table entry unpack: x low, y, note id high
    assign ent_x  = ram_rdata[POS_W-1:0];
    assign ent_y  = ram_rdata[2*POS_W-1:POS_W];
    assign ent_id = ram_rdata[ENTRY_W-1:2*POS_W];
    assign abs_dx = (ent_x > r_x) ? (ent_x - r_x) : (r_x - ent_x);
    assign abs_dy = (ent_y > r_y) ? (ent_y - r_y) : (r_y - ent_y);
    assign sum_sq = r_sq + r_prod[DIST_W-1:0];

    assign idx_p1  = CNT_W'(r_idx) + CNT_W'(1);
    assign idx_p2  = CNT_W'(r_idx) + CNT_W'(2);
    assign best_p1 = CNT_W'(r_best) + CNT_W'(1);

    // Pitch in Q8.8: base plus column term plus row term dropped to Q8.8
    assign pitch_sum = r_acc + ACC_W'(r_prod >> 8);

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SRCH_X: begin
                mul_a = MUL_W'(abs_dx);
                mul_b = MUL_W'(abs_dx);
            end
            S_SRCH_Y: begin
                mul_a = MUL_W'(r_dy);
                mul_b = MUL_W'(r_dy);
            end
            S_MUL_COL: begin
                mul_a = MUL_W'(r_quot);
                mul_b = r_col_step;
            end
            S_MUL_ROW: begin
                mul_a = MUL_W'(r_dyr);
                mul_b = r_row_step;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // RAM address select
    always_comb begin
        ram_raddr = r_idx;
        case (r_state)
            S_SRCH_RD:  ram_raddr = r_idx;
            S_SRCH_CMP: ram_raddr = r_idx + 1'b1;
            S_NOTE_RD:  ram_raddr = r_best;
            S_RM_RD:    ram_raddr = r_idx + 1'b1;
            default:    ram_raddr = r_idx;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_best       = r_best;
        n_div_cnt    = r_div_cnt;
        n_out_valid  = r_out_valid;
        n_x          = r_x;
        n_y          = r_y;
        n_nid        = r_nid;
        n_dyr        = r_dyr;
        n_quot       = r_quot;
        n_rem        = r_rem;
        n_acc        = r_acc;
        n_dy         = r_dy;
        n_sq         = r_sq;
        n_best_d     = r_best_d;
        n_res_status = r_res_status;
        n_res_pitch  = r_res_pitch;
        n_res_id     = r_res_id;
        n_out_status = r_out_status;
        n_out_pitch  = r_out_pitch;
        n_out_id     = r_out_id;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = {r_nid, r_y, r_x};

        // Result register drains independently
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    n_x         = x_c;
                    n_y         = y_c;
                    n_nid       = s_axis_tdata[ENTRY_W-1:2*POS_W];
                    n_dyr       = DYR_W'(SCREEN_H) - DYR_W'(y_c);
                    n_quot      = x_c;
                    n_rem       = '0;
                    n_div_cnt   = '0;
                    n_idx       = '0;
                    n_res_pitch = '0;
                    n_res_id    = '0;
                    if (!s_axis_tuser) begin
                        if (32'(r_count) >= MAX_TOUCHES) begin
                            n_res_status = ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_DIV;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = ST_NO_TOUCH;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_SRCH_RD;
                        end
                    end
                end
            end
            // Restoring division, one quotient bit per cycle
            S_DIV: begin
                n_rem     = div_ge ? CW_W'(div_trial - {1'b0, cw_eff}) : CW_W'(div_trial);
                n_quot    = {r_quot[POS_W-2:0], div_ge};
                n_div_cnt = r_div_cnt + 1'b1;
                if (32'(r_div_cnt) == POS_W - 1) begin
                    n_state = S_MUL_COL;
                end
            end
            S_MUL_COL: begin
                n_state = S_MUL_ROW;
            end
            S_MUL_ROW: begin
                n_acc   = ACC_W'(BASE_PITCH * 256) + ACC_W'(r_prod);
                n_state = S_DOWN_FIN;
            end
            // Saturate pitch, append the touch
            S_DOWN_FIN: begin
                n_res_pitch  = (|pitch_sum[ACC_W-1:PITCH_W]) ? '1 : pitch_sum[PITCH_W-1:0];
                n_res_id     = r_nid;
                n_res_status = ST_NOTE_ON;
                ram_we       = 1'b1;
                ram_waddr    = r_count[IDX_W-1:0];
                n_count      = r_count + 1'b1;
                n_state      = S_DONE;
            end
            // Nearest-touch search: square dx, square dy, then compare, for each entry
            S_SRCH_RD: begin
                n_state = S_SRCH_X;
            end
            S_SRCH_X: begin
                n_dy    = abs_dy;
                n_state = S_SRCH_Y;
            end
            S_SRCH_Y: begin
                n_sq    = r_prod[DIST_W-1:0];
                n_state = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (r_idx == '0 || sum_sq < r_best_d) begin
                    n_best   = r_idx;
                    n_best_d = sum_sq;
                end
                if (idx_p1 == r_count) begin
                    n_state = S_NOTE_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SRCH_X;
                end
            end
            S_NOTE_RD: begin
                n_state = S_NOTE;
            end
            S_NOTE: begin
                n_res_id     = ent_id;
                n_res_status = ST_NOTE_OFF;
                n_idx        = r_best;
                if (best_p1 < r_count) begin
                    n_state = S_RM_RD;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            // Shift later entries down by one
            S_RM_RD: begin
                n_state = S_RM_WR;
            end
            S_RM_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                n_idx     = r_idx + 1'b1;
                if (idx_p2 < r_count) begin
                    n_state = S_RM_RD;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_pitch  = r_res_pitch;
                    n_out_id     = r_res_id;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_best      <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_col_width <= RST_COLUMN_WIDTH;
            r_col_step  <= RST_COLUMN_STEP;
            r_row_step  <= RST_ROW_STEP;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_best      <= n_best;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_COLUMN_WIDTH: r_col_width <= i_cfg_data[CW_W-1:0];
                    CFG_COLUMN_STEP:  r_col_step  <= i_cfg_data[STEP_W-1:0];
                    CFG_ROW_STEP:     r_row_step  <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_x          <= n_x;
        r_y          <= n_y;
        r_nid        <= n_nid;
        r_dyr        <= n_dyr;
        r_quot       <= n_quot;
        r_rem        <= n_rem;
        r_prod       <= mul_p;
        r_acc        <= n_acc;
        r_dy         <= n_dy;
        r_sq         <= n_sq;
        r_best_d     <= n_best_d;
        r_res_status <= n_res_status;
        r_res_pitch  <= n_res_pitch;
        r_res_id     <= n_res_id;
        r_out_status <= n_out_status;
        r_out_pitch  <= n_out_pitch;
        r_out_id     <= n_out_id;
    end

    // Touch table
    tfnt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TOUCHES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = M_TDATA_W'({r_out_id, r_out_pitch});

endmodule

/* hdl/tfnt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfnt_checker: port-level checks for the note tracker
// Watches the top level's stream ports and flags ordering or payload slips.
// ----------------------------------------------------------------------------
module tfnt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [tfnt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input logic [tfnt_pkg::STAT_W-1:0]       m_axis_tuser
);

    import tfnt_pkg::*;

    // Reset drops any pending result
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // An accepted item keeps the block busy in the next cycle
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // Dropped or unmatched touches carry zero pitch and zero id
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NO_TOUCH || m_axis_tuser == ST_FULL)
        |-> m_axis_tdata == '0)
        else $error("reject result carries nonzero payload");

    // Note-off results carry zero pitch
    a_off_no_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_NOTE_OFF
        |-> m_axis_tdata[PITCH_W-1:0] == '0)
        else $error("note off with nonzero pitch");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind touch_finger_note_tracker_top tfnt_checker u_tfnt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
